FILE: design/first_fit_coalescing_allocator_core_macros.svh
// Assertion macros for the first-fit allocator core.
// Used by first_fit_coalescing_allocator_core.sv; expects clk and rst_n in scope.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FFCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffca: same-cycle check failed");
// next-cycle implication
`define FFCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffca: next-cycle check failed");
`else
`define FFCA_ASSERT_SAME(lbl, ante, cons)
`define FFCA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/ffca_pkg.sv
// Shared types and constants for the first-fit coalescing allocator.
// No dependencies; imported by ffca_ram, ffca_seq and the top level.
`default_nettype none

package ffca_pkg;

  localparam int unsigned MAX_FREE_BLOCKS_DEF = 64;
  localparam int unsigned CFG_IDX_W           = 1;
  localparam logic [15:0] AREA_START_RST      = 16'd0;
  localparam logic [15:0] AREA_SIZE_RST       = 16'd3;
  localparam logic [15:0] AREA_MIN            = 16'd3;
  localparam logic [15:0] AREA_OVERHEAD       = 16'd2;
  localparam logic [16:0] LEN_LIMIT           = 17'h0FFFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_START = 1'b0,
    CFG_AREA_SIZE  = 1'b1
  } cfg_idx_t;

  // request opcodes
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] amount;
    logic [15:0] block_seg;
  } in_req_t;

  typedef struct packed {
    logic [15:0] seg_out;
    logic [1:0]  status;
    logic [15:0] avail_paras;
  } out_rsp_t;

  // one free-table entry
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
  } entry_t;

  // sequencer state
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHDN,
    S_SHUP,
    S_PUT,
    S_DONE
  } seq_state_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
    logic full;
  } seq_stat_t;

endpackage

`default_nettype wire

FILE: design/first_fit_coalescing_allocator_core.sv
// First-fit free-block allocator with coalescing for one paragraph-addressed area.
// Request channel (in_valid/in_ready/in_req) carries cmd, amount and block_seg;
// result channel (out_valid/out_ready/out_rsp) returns seg_out, status, avail_paras.
// cfg_we/cfg_index/cfg_wdata set area_start (0) and area_size (1); they apply at
// the next init request. The user must write them only while the block is idle;
// the block itself does not enforce this. One request is worked at a time.
// Init, no-op and zero-length free go straight to the result. Allocate and free
// scan the table through the registered read of the free-table RAM, one entry
// per cycle, and stop at the first hit. Dropping an entry shifts the entries
// above it down by one; inserting one shifts them up and writes the new entry.
// The next request is accepted in the cycle the previous result appears.
// A finished result waits in an output register; the sequencer may accept and
// finish the next request meanwhile and then holds its result until the output
// register frees. Reset (rst_n, synchronous) empties the table, zeroes the free
// total and sets area_start to 0, area_size to 3; table RAM needs no clearing.
// Depends on ffca_pkg, ffca_ram, ffca_seq and the assertion macro header.
`default_nettype none
`include "first_fit_coalescing_allocator_core_macros.svh"

module first_fit_coalescing_allocator_core
  import ffca_pkg::*;
#(
  parameter int unsigned MAX_FREE_BLOCKS = MAX_FREE_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_req_t              in_req,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_rsp_t                  out_rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  localparam int unsigned AW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_FREE_BLOCKS + 1);

  logic [15:0] area_start_r;
  logic [15:0] area_size_r;
  logic        out_valid_r;
  out_rsp_t    out_rsp_r;

  seq_stat_t   stat;
  out_rsp_t    seq_rsp;
  logic        rsp_take;
  logic        start;

  logic          ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  entry_t        ram_wdata, ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_start_r <= AREA_START_RST;
      area_size_r  <= AREA_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AREA_START: area_start_r <= cfg_wdata;
        CFG_AREA_SIZE:  area_size_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // request handshake
  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;

  // output register: loads when empty or being drained
  assign rsp_take = stat.done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_rsp_r <= seq_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  ffca_ram #(
    .DEPTH (MAX_FREE_BLOCKS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffca_seq #(
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
    .AW              (AW),
    .CW              (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (in_req),
    .area_start (area_start_r),
    .area_size  (area_size_r),
    .take       (rsp_take),
    .stat       (stat),
    .rsp        (seq_rsp),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  // checks
  `FFCA_ASSERT_NEXT(a_busy_after_accept, start, !in_ready)
  `FFCA_ASSERT_NEXT(a_idle_after_handover, rsp_take, in_ready && out_valid)
  `FFCA_ASSERT_SAME(a_status_code, out_valid, out_rsp.status <= ST_FULL)
  `FFCA_ASSERT_SAME(a_full_refusal, stat.done && (seq_rsp.status == ST_FULL), stat.full)

endmodule

`default_nettype wire

FILE: design/ffca_ram.sv
// Free-table memory: one write port, one read port, registered read data.
// Depends on ffca_pkg for the entry type.
`default_nettype none

module ffca_ram
  import ffca_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_FREE_BLOCKS_DEF,
  parameter int unsigned AW    = $clog2(MAX_FREE_BLOCKS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/ffca_seq.sv
// Command sequencer: scans the free table, decides the update and shifts entries.
// Depends on ffca_pkg; drives the ffca_ram ports from the top level.
`default_nettype none

module ffca_seq
  import ffca_pkg::*;
#(
  parameter int unsigned MAX_FREE_BLOCKS = MAX_FREE_BLOCKS_DEF,
  parameter int unsigned AW              = $clog2(MAX_FREE_BLOCKS_DEF),
  parameter int unsigned CW              = $clog2(MAX_FREE_BLOCKS_DEF + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire in_req_t       req,
  input  wire logic [15:0]   area_start,
  input  wire logic [15:0]   area_size,
  input  wire logic          take,
  output seq_stat_t          stat,
  output out_rsp_t           rsp,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output entry_t             ram_wdata,
  input  wire entry_t        ram_rdata
);

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FREE_BLOCKS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  seq_state_t    state_r, state_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [15:0]   amount_r, amount_nxt;
  logic [15:0]   seg_r, seg_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   total_r, total_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  entry_t        prev_r, prev_nxt;
  entry_t        cur_r, cur_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic [15:0]   rsp_seg_r, rsp_seg_nxt;
  status_t       rsp_st_r, rsp_st_nxt;

  // merge arithmetic for the decision step
  logic          hit;
  logic [16:0]   fwd_end, fwd_sum, prev_end, back_sum;
  logic          fwd, back;
  logic [15:0]   len2;
  logic [CW-1:0] prev_idx, pend_up, pend_dn;

  assign hit = chk_vld_r &&
               ((cmd_r == CMD_ALLOC) ? (ram_rdata.len >= amount_r)
                                     : (ram_rdata.base >= seg_r));

  assign fwd_end  = {1'b0, seg_r} + {1'b0, amount_r};
  assign fwd_sum  = {1'b0, amount_r} + {1'b0, cur_r.len};
  assign fwd      = found_r && (fwd_end == {1'b0, cur_r.base}) && (fwd_sum <= LEN_LIMIT);
  assign len2     = fwd ? fwd_sum[15:0] : amount_r;
  assign prev_end = {1'b0, prev_r.base} + {1'b0, prev_r.len};
  assign back_sum = {1'b0, prev_r.len} + {1'b0, len2};
  assign back     = (pos_r != '0) && (prev_end == {1'b0, seg_r}) && (back_sum <= LEN_LIMIT);
  assign prev_idx = pos_r - CNT_ONE;
  assign pend_up  = pend_idx_r + CNT_ONE;
  assign pend_dn  = pend_idx_r - CNT_ONE;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      total_r    <= '0;
      chk_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      chk_vld_r  <= chk_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    amount_r   <= amount_nxt;
    seg_r      <= seg_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    sh_r       <= sh_nxt;
    pend_idx_r <= pend_idx_nxt;
    rsp_seg_r  <= rsp_seg_nxt;
    rsp_st_r   <= rsp_st_nxt;
  end

  // next state, memory accesses
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    amount_nxt   = amount_r;
    seg_nxt      = seg_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    rd_idx_nxt   = rd_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    sh_nxt       = sh_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    rsp_seg_nxt  = rsp_seg_r;
    rsp_st_nxt   = rsp_st_r;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = req.cmd;
          amount_nxt  = req.amount;
          seg_nxt     = req.block_seg;
          rsp_seg_nxt = '0;
          rsp_st_nxt  = ST_OK;
          rd_idx_nxt  = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_DONE;
          if (req.cmd == CMD_INIT) begin
            // one free block spanning the area minus header and end marker
            if (area_size >= AREA_MIN) begin
              ram_we    = 1'b1;
              ram_wdata = '{base: area_start + 16'd1, len: area_size - AREA_OVERHEAD};
              count_nxt = CNT_ONE;
              total_nxt = area_size - AREA_OVERHEAD;
            end else begin
              count_nxt = '0;
              total_nxt = '0;
            end
          end else if (req.cmd == CMD_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (req.cmd == CMD_FREE && req.amount != '0) begin
            state_nxt = S_SCAN;
          end
        end
      end

      // pipelined scan: issue read of entry rd_idx, test entry read last cycle
      S_SCAN: begin
        if (hit) begin
          pos_nxt     = chk_idx_r;
          found_nxt   = 1'b1;
          cur_nxt     = ram_rdata;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_ACT;
        end else begin
          if (chk_vld_r) begin
            prev_nxt = ram_rdata;
          end
          if (rd_idx_r < count_r) begin
            ram_re      = 1'b1;
            ram_raddr   = rd_idx_r[AW-1:0];
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = rd_idx_r;
            rd_idx_nxt  = rd_idx_r + CNT_ONE;
          end else begin
            chk_vld_nxt = 1'b0;
            if (!chk_vld_r) begin
              pos_nxt   = count_r;
              found_nxt = 1'b0;
              state_nxt = S_ACT;
            end
          end
        end
      end

      // apply the decision for the located entry
      S_ACT: begin
        state_nxt    = S_DONE;
        pend_vld_nxt = 1'b0;
        if (cmd_r == CMD_ALLOC) begin
          if (!found_r) begin
            rsp_st_nxt = ST_NOFIT;
          end else begin
            rsp_seg_nxt = cur_r.base;
            if (amount_r != '0) begin
              total_nxt = total_r - amount_r;
              if (cur_r.len == amount_r) begin
                sh_nxt    = pos_r + CNT_ONE;
                state_nxt = S_SHDN;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_r[AW-1:0];
                ram_wdata = '{base: cur_r.base + amount_r, len: cur_r.len - amount_r};
              end
            end
          end
        end else begin
          if (!fwd && !back) begin
            if (count_r == CNT_MAX) begin
              rsp_st_nxt = ST_FULL;
            end else begin
              total_nxt = total_r + amount_r;
              sh_nxt    = count_r;
              state_nxt = S_SHUP;
            end
          end else if (fwd && !back) begin
            total_nxt = total_r + amount_r;
            ram_we    = 1'b1;
            ram_waddr = pos_r[AW-1:0];
            ram_wdata = '{base: seg_r, len: len2};
          end else begin
            // grow the lower neighbor; absorb the upper one as well when both merge
            total_nxt = total_r + amount_r;
            ram_we    = 1'b1;
            ram_waddr = prev_idx[AW-1:0];
            ram_wdata = '{base: prev_r.base, len: back_sum[15:0]};
            if (fwd) begin
              sh_nxt    = pos_r + CNT_ONE;
              state_nxt = S_SHDN;
            end
          end
        end
      end

      // close the gap: entry k+1 moves to k, read ahead by one
      S_SHDN: begin
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_dn[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (sh_r < count_r) begin
          ram_re       = 1'b1;
          ram_raddr    = sh_r[AW-1:0];
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = sh_r;
          sh_nxt       = sh_r + CNT_ONE;
        end else begin
          pend_vld_nxt = 1'b0;
          if (!pend_vld_r) begin
            count_nxt = count_r - CNT_ONE;
            state_nxt = S_DONE;
          end
        end
      end

      // open a gap at pos: entry k-1 moves to k, from the top down
      S_SHUP: begin
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_up[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (sh_r > pos_r) begin
          ram_re       = 1'b1;
          ram_raddr    = AW'(sh_r - CNT_ONE);
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = sh_r - CNT_ONE;
          sh_nxt       = sh_r - CNT_ONE;
        end else begin
          pend_vld_nxt = 1'b0;
          if (!pend_vld_r) begin
            state_nxt = S_PUT;
          end
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = '{base: seg_r, len: amount_r};
        count_nxt = count_r + CNT_ONE;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign stat = '{idle: (state_r == S_IDLE),
                  done: (state_r == S_DONE),
                  full: (count_r == CNT_MAX)};

  assign rsp = '{seg_out: rsp_seg_r, status: rsp_st_r, avail_paras: total_r};

endmodule

`default_nettype wire
